// ===== sv/tdet_pkg.sv =====
package tdet_pkg;

  typedef enum logic [1:0] {
    FUNC_RESET = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_EVENT = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [1:0] MATCH_NONE    = 2'd0;
  localparam logic [1:0] MATCH_RUNNING = 2'd1;
  localparam logic [1:0] MATCH_DONE    = 2'd2;

  localparam logic [7:0] CC_SUCCESS      = 8'd1;
  localparam logic [7:0] CC_SHORT_PACKET = 8'd13;

  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] trb_addr;
    logic [23:0] offset;
    logic [23:0] length;
    logic [31:0] event_status;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  match;
    logic [23:0] transferred;
    logic [7:0]  code;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [23:0] offset;
    logic [23:0] length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/tdet_ram.sv =====
module tdet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/transfer_descriptor_event_tracker_unit.sv =====
// A reset, add or unused item goes from S_IDLE to S_OUT, which loads its result into the output
// register. An event searches the entries in order in S_SCAN, then goes through S_CALC to S_OUT
// when an entry matches, to S_OUT when none matches, and from S_IDLE to S_OUT on an empty table.
// Throughput: one item at a time; the next item is accepted the cycle after the result is loaded.
// The entry search reads one table entry per cycle from the single read port of the entry RAM.
// Reset (synchronous, rst_n low) empties the table and clears the count, flag and output valid.
module transfer_descriptor_event_tracker_unit
  import tdet_pkg::*;
#(
  parameter int MAX_ENTRIES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [23:0]       total_r, total_nxt;
  logic              short_r, short_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       status_r, status_nxt;
  logic [23:0]       hit_off_r, hit_off_nxt;
  logic [23:0]       hit_len_r, hit_len_nxt;
  logic              hit_last_r, hit_last_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              accept;
  logic              ram_we;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;
  logic              last_idx;
  logic [23:0]       residue;
  logic [23:0]       clamped;
  logic [24:0]       sum;
  logic [23:0]       sum_sat;
  logic [7:0]        cc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign ram_we    = accept && (in_item.func == FUNC_ADD) && (count_r < CNT_W'(MAX_ENTRIES));
  assign ram_wdata = '{addr: in_item.trb_addr, offset: in_item.offset, length: in_item.length};
  assign ram_rdata = entry_t'(ram_rbits);

  tdet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rbits)
  );

  assign last_idx = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign residue  = status_r[23:0];
  assign cc       = status_r[31:24];
  assign clamped  = (residue > hit_len_r) ? hit_len_r : residue;
  assign sum      = {1'b0, hit_off_r} + {1'b0, hit_len_r} - {1'b0, clamped};
  assign sum_sat  = sum[24] ? COUNT_MAX : sum[23:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    short_nxt     = short_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    status_nxt    = status_r;
    hit_off_nxt   = hit_off_r;
    hit_len_nxt   = hit_len_r;
    hit_last_nxt  = hit_last_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt    = '0;
          addr_nxt   = in_item.trb_addr;
          status_nxt = in_item.event_status;
          idx_nxt    = '0;
          state_nxt  = S_OUT;
          case (in_item.func)
            FUNC_RESET: begin
              count_nxt = '0;
              total_nxt = in_item.length;
              short_nxt = 1'b0;
            end
            FUNC_ADD: begin
              if (ram_we) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FUNC_EVENT: begin
              if (count_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ram_rdata.addr == addr_r) begin
          hit_off_nxt  = ram_rdata.offset;
          hit_len_nxt  = ram_rdata.length;
          hit_last_nxt = last_idx;
          state_nxt    = S_CALC;
        end else if (last_idx) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_CALC: begin
        if (hit_len_r != '0 && !short_r) begin
          total_nxt = sum_sat;
        end
        if (cc == CC_SHORT_PACKET) begin
          short_nxt = 1'b1;
        end
        if (!hit_last_r && (cc == CC_SUCCESS || cc == CC_SHORT_PACKET)) begin
          res_nxt = '{match: MATCH_RUNNING, transferred: '0, code: '0};
        end else begin
          res_nxt = '{match: MATCH_DONE, transferred: total_nxt, code: cc};
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      short_r     <= short_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    addr_r     <= addr_nxt;
    status_r   <= status_nxt;
    hit_off_r  <= hit_off_nxt;
    hit_len_r  <= hit_len_nxt;
    hit_last_r <= hit_last_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds the table size");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CNT_W'(idx_r) < count_r)
    else $error("search index beyond the filled entries");

  a_zero_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.match != MATCH_DONE |-> out_r.transferred == '0 && out_r.code == '0)
    else $error("result that is not done carries a count or code");

  a_reset_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.func == FUNC_RESET |=> count_r == '0 && !short_r)
    else $error("descriptor reset did not empty the table");

endmodule
